### hw/rtl/pperim_pkg.sv
// ----------------------------------------------------------------------------
// pperim_pkg
// Types and fixed constants shared by the polygon perimeter accumulator.
// ----------------------------------------------------------------------------
package pperim_pkg;

   // result perimeter is always reported on 32 bits
   localparam int OUT_BITS = 32;

   // vertex count saturates here; fewer than this means a degenerate polygon
   localparam logic [1:0] COUNT_FULL = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLOSE,
      ST_SQX,
      ST_SQY,
      ST_LOAD,
      ST_ROOT,
      ST_ACC,
      ST_EMIT
   } st_type;

   typedef struct packed {
      logic start;
   } sqrt_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_sts_type;

endpackage

### hw/rtl/pperim_if.sv
// ----------------------------------------------------------------------------
// pperim_if
// Valid/ready channels for vertices in and perimeter results out.
// ----------------------------------------------------------------------------
interface pperim_req_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] x;
   logic signed [COORD_BITS-1:0] y;
   logic                         last;

   modport source (output valid, output x, output y, output last, input ready);
   modport sink   (input valid, input x, input y, input last, output ready);
endinterface

interface pperim_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] perimeter;
   logic        too_few;
   logic        overflow;

   modport source (output valid, output perimeter, output too_few, output overflow,
                   input ready);
   modport sink   (input valid, input perimeter, input too_few, input overflow,
                   output ready);
endinterface

### hw/rtl/pperim_isqrt.sv
// ----------------------------------------------------------------------------
// pperim_isqrt
// Bit-serial restoring integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module pperim_isqrt #(
   parameter int ROOT_BITS = 17
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pperim_pkg::sqrt_ctl_type      ctl,
   input  logic [2*ROOT_BITS-1:0]        radicand,
   output pperim_pkg::sqrt_sts_type      sts,
   output logic [ROOT_BITS-1:0]          root
);
   import pperim_pkg::*;

   localparam int CNT_W = $clog2(ROOT_BITS);
   localparam int REM_W = ROOT_BITS + 1;
   localparam int TRY_W = ROOT_BITS + 3;

   logic [2*ROOT_BITS-1:0] rad_ff,  rad_in;
   logic [REM_W-1:0]       rem_ff,  rem_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic [CNT_W-1:0]       cnt_ff,  cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [TRY_W-1:0] trial;
   logic [TRY_W-1:0] subtrahend;
   logic             fits;

   // bring down the next pair of radicand bits and try root*4+1
   assign trial      = {rem_ff, rad_ff[2*ROOT_BITS-1 -: 2]};
   assign subtrahend = TRY_W'({root_ff, 2'b01});
   assign fits       = trial >= subtrahend;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = rad_ff << 2;
         rem_in  = fits ? REM_W'(trial - subtrahend) : REM_W'(trial);
         root_in = {root_ff[ROOT_BITS-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ROOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign root     = root_ff;

   a_done_follows_busy : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("root done without a running iteration");

   a_busy_needs_start : assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> $past(ctl.start))
      else $error("iteration began without a start");

   a_count_in_range : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff <= CNT_W'(ROOT_BITS - 1)))
      else $error("iteration count ran past the root width");

endmodule

### hw/rtl/polygon_perimeter_accumulator.sv
// ----------------------------------------------------------------------------
// polygon_perimeter_accumulator
// Sums edge lengths of a polygon, one vertex per transfer, closing edge on
// the last vertex, and reports a saturated Q24.8 perimeter.
// ----------------------------------------------------------------------------
//  channel   dir   handshake              payload
//  req_ch    in    valid / ready          x, y (signed Q8.8), last
//  rsp_ch    out   valid / ready          perimeter (Q24.8), too_few, overflow
//
//  An edge runs a difference, two squares on one shared multiplier, a load,
//  then COORD_BITS + 1 root bits one per cycle, a check that the root is
//  done, and the saturating add. The first vertex only records its
//  position. A last vertex also runs an edge for the closing side, then an
//  emit step places the result. Reset is synchronous and clears the polygon
//  state. A result held in the output register only stalls the block when
//  the next result is ready to be placed.
// ----------------------------------------------------------------------------
module polygon_perimeter_accumulator #(
   parameter int COORD_BITS = 16,
   parameter int SUM_BITS   = 32
) (
   input logic         clock,
   input logic         reset,
   pperim_req_if.sink  req_ch,
   pperim_rsp_if.source rsp_ch
);
   import pperim_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int ROOT_W = C + 1;
   localparam int ADD_W  = ((SUM_BITS > ROOT_W) ? SUM_BITS : ROOT_W) + 1;

   function automatic logic [C-1:0] abs_diff(input logic [C-1:0] a, input logic [C-1:0] b);
      logic [C:0] d;
      logic [C:0] m;
      d = {a[C-1], a} - {b[C-1], b};
      m = d[C] ? (~d + 1'b1) : d;
      return m[C-1:0];
   endfunction

   st_type              state_ff,   state_in;
   logic [C-1:0]        first_x_ff, first_x_in;
   logic [C-1:0]        first_y_ff, first_y_in;
   logic [C-1:0]        prev_x_ff,  prev_x_in;
   logic [C-1:0]        prev_y_ff,  prev_y_in;
   logic [1:0]          count_ff,   count_in;
   logic [SUM_BITS-1:0] sum_ff,     sum_in;
   logic                sat_ff,     sat_in;
   logic                last_ff,    last_in;
   logic                closing_ff, closing_in;
   logic [C-1:0]        dx_ff,      dx_in;
   logic [C-1:0]        dy_ff,      dy_in;
   logic [2*C-1:0]      sqx_ff,     sqx_in;
   logic [2*C-1:0]      sqy_ff,     sqy_in;

   logic                rsp_valid_ff,    rsp_valid_in;
   logic [OUT_BITS-1:0] rsp_perimeter_ff, rsp_perimeter_in;
   logic                rsp_too_few_ff,   rsp_too_few_in;
   logic                rsp_overflow_ff,  rsp_overflow_in;

   logic                req_take;
   logic                emit_go;
   logic [C-1:0]        mul_op;
   logic [2*C-1:0]      product;
   logic [ADD_W-1:0]    total;
   logic                total_over;

   sqrt_ctl_type        sqrt_ctl;
   sqrt_sts_type        sqrt_sts;
   logic [2*ROOT_W-1:0] radicand;
   logic [ROOT_W-1:0]   edge_len;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign emit_go      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);

   // one multiplier, dx squared then dy squared
   assign mul_op   = (state_ff == ST_SQX) ? dx_ff : dy_ff;
   assign product  = (2*C)'(mul_op) * (2*C)'(mul_op);
   assign radicand = (2*ROOT_W)'(sqx_ff) + (2*ROOT_W)'(sqy_ff);

   // sum never exceeds its maximum, so any carry past SUM_BITS means saturation
   assign total      = ADD_W'(sum_ff) + ADD_W'(edge_len);
   assign total_over = |total[ADD_W-1:SUM_BITS];

   pperim_isqrt #(
      .ROOT_BITS (ROOT_W)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sqrt_ctl),
      .radicand (radicand),
      .sts      (sqrt_sts),
      .root     (edge_len)
   );

   always_comb begin
      state_in         = state_ff;
      first_x_in       = first_x_ff;
      first_y_in       = first_y_ff;
      prev_x_in        = prev_x_ff;
      prev_y_in        = prev_y_ff;
      count_in         = count_ff;
      sum_in           = sum_ff;
      sat_in           = sat_ff;
      last_in          = last_ff;
      closing_in       = closing_ff;
      dx_in            = dx_ff;
      dy_in            = dy_ff;
      sqx_in           = sqx_ff;
      sqy_in           = sqy_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      rsp_perimeter_in = rsp_perimeter_ff;
      rsp_too_few_in   = rsp_too_few_ff;
      rsp_overflow_in  = rsp_overflow_ff;
      sqrt_ctl.start   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               dx_in      = abs_diff(prev_x_ff, req_ch.x);
               dy_in      = abs_diff(prev_y_ff, req_ch.y);
               prev_x_in  = req_ch.x;
               prev_y_in  = req_ch.y;
               last_in    = req_ch.last;
               closing_in = 1'b0;
               if (count_ff == 2'd0) begin
                  first_x_in = req_ch.x;
                  first_y_in = req_ch.y;
               end
               if (count_ff != COUNT_FULL) begin
                  count_in = count_ff + 1'b1;
               end
               if (count_ff != 2'd0) begin
                  state_in = ST_SQX;
               end else if (req_ch.last) begin
                  state_in = ST_CLOSE;
               end
            end
         end
         ST_CLOSE: begin
            // closing side, back to the first vertex
            dx_in      = abs_diff(prev_x_ff, first_x_ff);
            dy_in      = abs_diff(prev_y_ff, first_y_ff);
            closing_in = 1'b1;
            state_in   = ST_SQX;
         end
         ST_SQX: begin
            sqx_in   = product;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sqy_in   = product;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            sqrt_ctl.start = 1'b1;
            state_in       = ST_ROOT;
         end
         ST_ROOT: begin
            if (sqrt_sts.done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (total_over) begin
               sum_in = '1;
               sat_in = 1'b1;
            end else begin
               sum_in = total[SUM_BITS-1:0];
            end
            if (closing_ff) begin
               state_in = ST_EMIT;
            end else if (last_ff) begin
               state_in = ST_CLOSE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in     = 1'b1;
               rsp_perimeter_in = OUT_BITS'(sum_ff);
               rsp_too_few_in   = (count_ff != COUNT_FULL);
               rsp_overflow_in  = sat_ff;
               first_x_in       = '0;
               first_y_in       = '0;
               prev_x_in        = '0;
               prev_y_in        = '0;
               count_in         = '0;
               sum_in           = '0;
               sat_in           = 1'b0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dx_ff            <= dx_in;
      dy_ff            <= dy_in;
      sqx_ff           <= sqx_in;
      sqy_ff           <= sqy_in;
      last_ff          <= last_in;
      closing_ff       <= closing_in;
      rsp_perimeter_ff <= rsp_perimeter_in;
      rsp_too_few_ff   <= rsp_too_few_in;
      rsp_overflow_ff  <= rsp_overflow_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_x_ff   <= first_x_in;
         first_y_ff   <= first_y_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.perimeter = rsp_perimeter_ff;
   assign rsp_ch.too_few   = rsp_too_few_ff;
   assign rsp_ch.overflow  = rsp_overflow_ff;

   a_start_when_free : assert property (@(posedge clock) disable iff (reset)
      sqrt_ctl.start |-> !sqrt_sts.busy)
      else $error("square root started while still running");

   a_idle_root_quiet : assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !sqrt_sts.busy)
      else $error("vertex accepted while an edge is in flight");

   a_emit_clears : assert property (@(posedge clock) disable iff (reset)
      emit_go |=> (count_ff == 2'd0) && (sum_ff == '0) && !sat_ff)
      else $error("polygon state not cleared after result");

   a_result_from_emit : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside the emit step");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the polygon perimeter accumulator. A directed table
// covers degenerate, extreme and textbook polygons. Random polygons then run
// under several idle and stall mixes. Every result is checked against a typed
// value from the table or against a bit-exact perimeter predictor.
// ----------------------------------------------------------------------------
module tb_top;
   import pperim_pkg::*;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               last;
   } vertex_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] perimeter;
      logic                too_few;
      logic                overflow;
   } result_type;

   typedef struct packed {
      vertex_type          v;
      logic                typed;
      logic [OUT_BITS-1:0] perimeter;
      logic                too_few;
      logic                overflow;
   } dir_row_type;

   localparam logic [63:0] SUM_MAX      = 64'hFFFF_FFFF;
   localparam int          ITEMS_PER_PH = 98;
   localparam int          HOLD_CYCLES  = 500;
   localparam int          TAIL_CYCLES  = 60;

   logic clock = 1'b0;
   logic reset;

   pperim_req_if #(.COORD_BITS(16)) req_if ();
   pperim_rsp_if                    rsp_if ();

   polygon_perimeter_accumulator #(
      .COORD_BITS(16),
      .SUM_BITS  (32)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // running state of the polygon predictor
   logic signed [15:0] poly_first_x, poly_first_y, poly_prev_x, poly_prev_y;
   logic [1:0]         poly_count;
   logic [63:0]        poly_sum;
   logic               poly_sat;

   result_type expected_perims[$];
   int         error_count;
   int         send_idle_pct;
   int         stall_pct;
   int         hold_request;
   int         hold_seen;
   int         hold_left;

   dir_row_type directed_rows [23] = '{
      // lone vertex straight after reset
      '{'{16'sd0, 16'sd0, 1'b1}, 1'b1, 32'd0, 1'b1, 1'b0},
      '{'{16'sh8000, 16'sh7FFF, 1'b1}, 1'b1, 32'd0, 1'b1, 1'b0},
      // two vertices at opposite corners, edge counted twice
      '{'{16'sh8000, 16'sh8000, 1'b0}, 1'b0, 32'd0, 1'b0, 1'b0},
      '{'{16'sh7FFF, 16'sh7FFF, 1'b1}, 1'b1, 32'd185360, 1'b1, 1'b0},
      '{'{16'sd0, 16'sd0, 1'b0}, 1'b0, 32'd0, 1'b0, 1'b0},
      '{'{16'sd768, 16'sd1024, 1'b1}, 1'b1, 32'd2560, 1'b1, 1'b0},
      // 3-4-5 triangle
      '{'{16'sd0, 16'sd0, 1'b0}, 1'b0, 32'd0, 1'b0, 1'b0},
      '{'{16'sd768, 16'sd0, 1'b0}, 1'b0, 32'd0, 1'b0, 1'b0},
      '{'{16'sd768, 16'sd1024, 1'b1}, 1'b1, 32'd3072, 1'b0, 1'b0},
      // full-range square
      '{'{16'sh8000, 16'sh8000, 1'b0}, 1'b0, 32'd0, 1'b0, 1'b0},
      '{'{16'sh7FFF, 16'sh8000, 1'b0}, 1'b0, 32'd0, 1'b0, 1'b0},
      '{'{16'sh7FFF, 16'sh7FFF, 1'b0}, 1'b0, 32'd0, 1'b0, 1'b0},
      '{'{16'sh8000, 16'sh7FFF, 1'b1}, 1'b1, 32'd262140, 1'b0, 1'b0},
      // coincident vertices
      '{'{16'sd5, 16'sd5, 1'b0}, 1'b0, 32'd0, 1'b0, 1'b0},
      '{'{16'sd5, 16'sd5, 1'b0}, 1'b0, 32'd0, 1'b0, 1'b0},
      '{'{16'sd5, 16'sd5, 1'b1}, 1'b1, 32'd0, 1'b0, 1'b0},
      // pentagon, count saturates
      '{'{16'sd100, -16'sd200, 1'b0}, 1'b0, 32'd0, 1'b0, 1'b0},
      '{'{-16'sd5, 16'sd7, 1'b0}, 1'b0, 32'd0, 1'b0, 1'b0},
      '{'{16'sh7FFF, 16'sh8000, 1'b0}, 1'b0, 32'd0, 1'b0, 1'b0},
      '{'{16'sd1, 16'sd1, 1'b0}, 1'b0, 32'd0, 1'b0, 1'b0},
      '{'{16'sh8000, 16'sd0, 1'b1}, 1'b0, 32'd0, 1'b0, 1'b0},
      // diagonal step, root floored
      '{'{-16'sd1, -16'sd1, 1'b0}, 1'b0, 32'd0, 1'b0, 1'b0},
      '{'{16'sd0, 16'sd0, 1'b1}, 1'b0, 32'd0, 1'b0, 1'b0}
   };

   function automatic logic [31:0] edge_length(input logic signed [15:0] ax,
                                               input logic signed [15:0] ay,
                                               input logic signed [15:0] bx,
                                               input logic signed [15:0] by);
      longint          dx, dy;
      longint unsigned sq, root, cand;
      int              b;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sq   = longint'(dx * dx) + longint'(dy * dy);
      root = 0;
      for (b = 17; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (cand * cand <= sq) root = cand;
      end
      return root[31:0];
   endfunction

   task automatic add_edge(input logic [31:0] len);
      if (64'(len) > SUM_MAX - poly_sum) begin
         poly_sum = SUM_MAX;
         poly_sat = 1'b1;
      end else begin
         poly_sum = poly_sum + 64'(len);
      end
   endtask

   task automatic clear_polygon();
      poly_first_x = '0;
      poly_first_y = '0;
      poly_prev_x  = '0;
      poly_prev_y  = '0;
      poly_count   = '0;
      poly_sum     = '0;
      poly_sat     = 1'b0;
   endtask

   task automatic advance_polygon(input vertex_type v, output bit closed,
                                  output result_type res);
      res = '0;
      if (poly_count == 2'd0) begin
         poly_first_x = v.x;
         poly_first_y = v.y;
      end else begin
         add_edge(edge_length(poly_prev_x, poly_prev_y, v.x, v.y));
      end
      poly_prev_x = v.x;
      poly_prev_y = v.y;
      if (poly_count < COUNT_FULL) poly_count = poly_count + 2'd1;
      closed = v.last;
      if (v.last) begin
         add_edge(edge_length(v.x, v.y, poly_first_x, poly_first_y));
         res.perimeter = poly_sum[31:0];
         res.too_few   = (poly_count < COUNT_FULL);
         res.overflow  = poly_sat;
         clear_polygon();
      end
   endtask

   task automatic report_error(input string msg);
      if (error_count < 40) $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic send_vertex(input vertex_type v, input bit typed,
                              input result_type typed_res);
      bit         closed;
      result_type pred;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.x     <= v.x;
      req_if.y     <= v.y;
      req_if.last  <= v.last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      advance_polygon(v, closed, pred);
      if (closed) expected_perims.push_back(typed ? typed_res : pred);
   endtask

   // valid drops in the step of the final transfer, then every result drains
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (expected_perims.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [15:0] random_coord();
      logic signed [15:0] c;
      case ($urandom_range(0, 9))
         0:       c = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         1, 2:    c = 16'($urandom_range(0, 600)) - 16'sd300;
         default: c = 16'($urandom);
      endcase
      return c;
   endfunction

   task automatic send_random_polygon(input int n, inout int sent);
      vertex_type v;
      int         i;
      for (i = 0; i < n; i++) begin
         v.x    = random_coord();
         v.y    = random_coord();
         v.last = (i == n - 1);
         send_vertex(v, 1'b0, '0);
         sent++;
      end
   endtask

   // result side: checks each transfer, then picks ready for the next edge
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_perims.size() == 0) begin
            report_error($sformatf("unexpected result perimeter=%0d", rsp_if.perimeter));
         end else begin
            want = expected_perims.pop_front();
            if (rsp_if.perimeter !== want.perimeter)
               report_error($sformatf("perimeter got %0d want %0d",
                                      rsp_if.perimeter, want.perimeter));
            if (rsp_if.too_few !== want.too_few)
               report_error($sformatf("too_few got %b want %b",
                                      rsp_if.too_few, want.too_few));
            if (rsp_if.overflow !== want.overflow)
               report_error($sformatf("overflow got %b want %b",
                                      rsp_if.overflow, want.overflow));
         end
      end
      if (hold_request != hold_seen) begin
         hold_seen = hold_request;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      #60_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      result_type fixed_res;
      int         phase, sent, i;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.x      = '0;
      req_if.y      = '0;
      req_if.last   = 1'b0;
      rsp_if.ready  = 1'b0;
      error_count   = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_request  = 0;
      hold_seen     = 0;
      hold_left     = 0;
      clear_polygon();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         fixed_res.perimeter = directed_rows[r].perimeter;
         fixed_res.too_few   = directed_rows[r].too_few;
         fixed_res.overflow  = directed_rows[r].overflow;
         send_vertex(directed_rows[r].v, directed_rows[r].typed, fixed_res);
      end
      drain_results();

      // long receiver hold-off while lone vertices keep arriving
      hold_request++;
      sent = 0;
      for (i = 0; i < 30; i++) send_random_polygon(1, sent);
      drain_results();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 83; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 83; end
            default: begin send_idle_pct = 33; stall_pct = 33; end
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PH) begin
            if ($urandom_range(0, 9) == 0) send_random_polygon($urandom_range(7, 20), sent);
            else                           send_random_polygon($urandom_range(1, 6), sent);
         end
         drain_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_perims.size() != 0) report_error("results still outstanding");
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### polygon_perimeter_accumulator.f
hw/rtl/pperim_pkg.sv
hw/rtl/pperim_if.sv
hw/rtl/pperim_isqrt.sv
hw/rtl/polygon_perimeter_accumulator.sv
tb/tb_top.sv
